[hdl/pcxrle_pkg.sv]
`timescale 1ns / 1ps

package pcxrle_pkg;

  // fixed sizes
  localparam int PALETTE_SIZE = 256;
  localparam int DIM_BITS     = 13;

  // image byte decoding
  localparam logic [7:0]          RUN_MARK = 8'hC0;
  localparam logic [DIM_BITS-1:0] COL_SAT  = 13'h1FFF;

  // input operation codes
  localparam logic OP_PALETTE = 1'b0;
  localparam logic OP_IMAGE   = 1'b1;

  // configuration register indexes
  localparam logic [1:0] REG_WIDTH  = 2'd0;
  localparam logic [1:0] REG_HEIGHT = 2'd1;
  localparam logic [1:0] REG_LINE   = 2'd2;

  typedef struct packed {
    logic       op;
    logic [7:0] data_byte;
    logic [7:0] palette_index;
    logic [7:0] pal_red;
    logic [7:0] pal_green;
    logic [7:0] pal_blue;
  } in_word_t;

  typedef struct packed {
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic [11:0] column;
    logic [11:0] row_index;
    logic        last_of_run;
    logic        end_of_image;
  } out_word_t;

  typedef struct packed {
    logic [1:0]          index;
    logic [DIM_BITS-1:0] value;
  } cfg_word_t;

endpackage

[hdl/pcxrle_if.sv]
`timescale 1ns / 1ps

interface pcxrle_in_if;
  logic                 valid;
  logic                 ready;
  pcxrle_pkg::in_word_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface pcxrle_out_if;
  logic                  valid;
  logic                  ready;
  pcxrle_pkg::out_word_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface pcxrle_cfg_if;
  logic                  valid;
  logic                  ready;
  pcxrle_pkg::cfg_word_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

[hdl/pcx_rle_palette_decoder.sv]
`timescale 1ns / 1ps
// pcx run-length decoder with 256-entry palette lookup
// stream: input words; op selects a palette entry write (index plus rgb) or
//   one compressed image byte. a byte of 0xC0 or above holds a run count and
//   the next image byte is the value; any other byte is a single pixel.
// pixels: one word per visible pixel with its rgb, column, row, a flag on the
//   last visible pixel of the byte and a flag on the last pixel of the image.
// cfg: register writes (0 width, 1 height, 2 line bytes), always ready;
//   write only while the decoder is idle and all pixels are delivered.
// steps: palette writes and run-count bytes are taken while idle. a value byte
//   is accepted while its palette entry is read into a register, then each
//   visible pixel is sent, then the byte is closed (row wrap); pixels past
//   the width are skipped all at once. the pixel output register sets the
//   pace: one pixel per cycle while the receiver takes them.
// stall: while the receiver holds off, the output register keeps its pixel
//   and the run counter waits; no input word is taken until the byte is done.
// reset: counters, run state and registers (all three to 1) are cleared;
//   palette ram contents are not and must be written before use.
module pcx_rle_palette_decoder #(
  parameter int MAX_DIM = 4096
) (
  input  logic                 clk,
  input  logic                 rst,
  pcxrle_in_if.sink            stream,
  pcxrle_out_if.source         pixels,
  pcxrle_cfg_if.sink           cfg
);

  localparam int DW = pcxrle_pkg::DIM_BITS;
  // width and height limit, never beyond what the 13-bit registers can hold
  localparam logic [DW-1:0] DIM_CAP = (MAX_DIM > 8191) ? 13'h1FFF : 13'(MAX_DIM);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_RUN  = 1'b1;

  // configuration registers
  logic [DW-1:0] image_width;
  logic [DW-1:0] image_height;
  logic [DW-1:0] line_bytes;

  // decode state
  logic          state;
  logic          awaiting_value;
  logic [5:0]    pending_run;
  logic [5:0]    remaining;
  logic [DW-1:0] column_count;
  logic [11:0]   row_count;
  logic          image_done;

  // palette ram and its registered read word
  logic [23:0] palette_store [pcxrle_pkg::PALETTE_SIZE];
  logic [23:0] pal_data;

  // output register
  logic                  out_valid;
  pcxrle_pkg::out_word_t out_word;

  logic          accept;
  logic          is_image;
  logic          img_live;
  logic          out_free;
  logic          visible;
  logic          emit;
  logic          last_vis;
  logic          eoi;
  logic [DW-1:0] eff_w;
  logic [DW-1:0] eff_h;
  logic [DW-1:0] col_inc;
  logic [DW-1:0] col_skip;
  logic [DW:0]   skip_sum;
  logic [DW:0]   col_plus1;
  logic [DW-1:0] row_plus1;

  assign stream.ready = (state == ST_IDLE);
  assign cfg.ready    = 1'b1;
  assign pixels.valid = out_valid;
  assign pixels.data  = out_word;

  assign accept   = stream.valid && stream.ready;
  assign is_image = (stream.data.op == pcxrle_pkg::OP_IMAGE);

  // dimensions limited to the supported maximum
  assign eff_w = (image_width  > DIM_CAP) ? DIM_CAP : image_width;
  assign eff_h = (image_height > DIM_CAP) ? DIM_CAP : image_height;

  assign row_plus1 = {1'b0, row_count} + 13'd1;
  assign img_live  = !image_done && ({1'b0, row_count} < eff_h);
  assign out_free  = !out_valid || pixels.ready;
  assign visible   = (column_count < eff_w);

  // column advance: saturating step for one pixel, jump for a hidden tail
  assign col_inc   = (column_count < pcxrle_pkg::COL_SAT) ? column_count + 13'd1
                                                           : column_count;
  assign skip_sum  = {1'b0, column_count} + 14'(remaining);
  assign col_skip  = (skip_sum > {1'b0, pcxrle_pkg::COL_SAT}) ? pcxrle_pkg::COL_SAT
                                                              : skip_sum[DW-1:0];

  // visible pixels form a prefix of the run, so the last one is the end of
  // the run or the one just before the width
  assign col_plus1 = {1'b0, column_count} + 14'd1;
  assign last_vis  = (remaining == 6'd1) || (col_plus1 >= {1'b0, eff_w});
  assign eoi       = (col_plus1 == {1'b0, eff_w}) && (row_plus1 == eff_h);

  assign emit = (state == ST_RUN) && (remaining != 6'd0) && visible && out_free;

  // palette ram: one write or one read per accepted word
  always_ff @(posedge clk) begin
    if (accept && !is_image) begin
      palette_store[stream.data.palette_index] <=
        {stream.data.pal_red, stream.data.pal_green, stream.data.pal_blue};
    end
    if (accept && is_image) begin
      pal_data <= palette_store[stream.data.data_byte];
    end
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= 13'd1;
      image_height <= 13'd1;
      line_bytes   <= 13'd1;
    end else if (cfg.valid && cfg.ready) begin
      case (cfg.data.index)
        pcxrle_pkg::REG_WIDTH:  image_width  <= cfg.data.value;
        pcxrle_pkg::REG_HEIGHT: image_height <= cfg.data.value;
        pcxrle_pkg::REG_LINE:   line_bytes   <= cfg.data.value;
        default: ;
      endcase
    end
  end

  // run decoding and column / row tracking
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= ST_IDLE;
      awaiting_value <= 1'b0;
      pending_run    <= 6'd0;
      remaining      <= 6'd0;
      column_count   <= '0;
      row_count      <= '0;
      image_done     <= 1'b0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (accept && is_image && img_live) begin
            if (!awaiting_value && (stream.data.data_byte >= pcxrle_pkg::RUN_MARK)) begin
              // count byte: hold the count until the value arrives
              awaiting_value <= 1'b1;
              pending_run    <= stream.data.data_byte[5:0];
            end else begin
              remaining      <= awaiting_value ? pending_run : 6'd1;
              awaiting_value <= 1'b0;
              pending_run    <= 6'd0;
              state          <= ST_RUN;
            end
          end
        end
        ST_RUN: begin
          if (remaining == 6'd0) begin
            // byte done: wrap the row once the line is full
            if (column_count >= line_bytes) begin
              column_count <= '0;
              if (row_plus1 >= eff_h) begin
                image_done <= 1'b1;
              end else begin
                row_count <= row_plus1[11:0];
              end
            end
            state <= ST_IDLE;
          end else if (visible) begin
            if (out_free) begin
              column_count <= col_inc;
              remaining    <= remaining - 6'd1;
            end
          end else begin
            // hidden pixels are only counted
            column_count <= col_skip;
            remaining    <= 6'd0;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // pixel output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (pixels.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_word.red          <= pal_data[23:16];
      out_word.green        <= pal_data[15:8];
      out_word.blue         <= pal_data[7:0];
      out_word.column       <= column_count[11:0];
      out_word.row_index    <= row_count;
      out_word.last_of_run  <= last_vis;
      out_word.end_of_image <= eoi;
    end
  end

  // a closed byte always returns to idle
  a_close_to_idle: assert property (@(posedge clk) disable iff (rst)
    (state == ST_RUN && remaining == 6'd0) |=> (state == ST_IDLE))
    else $error("decoder did not return to idle after closing a byte");

  // an image byte after the end of the image starts no run
  a_done_ignores: assert property (@(posedge clk) disable iff (rst)
    (accept && is_image && image_done) |=> (state == ST_IDLE))
    else $error("image byte after end of image started a run");

  // end of image is always the last visible pixel of its byte
  a_eoi_last: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_word.end_of_image) |-> out_word.last_of_run)
    else $error("end of image without last of run");

  // a new pixel is never loaded over one the receiver has not taken
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !pixels.ready) |-> !emit)
    else $error("pixel output register overwritten");

endmodule

[sim/tb_top.sv]
`timescale 1ns / 1ps

module tb_top;

  localparam int MAX_DIM = 4096;
  // cycles to let a byte with no visible pixel finish: accept, one skip and close,
  // with a wide margin
  localparam int SETTLE_CYCLES = 80;
  // index past the last register, the block must ignore it
  localparam logic [1:0] REG_SPARE = 2'd3;

  logic clk;
  logic rst;

  pcxrle_in_if  stream_if ();
  pcxrle_out_if pixels_if ();
  pcxrle_cfg_if cfg_if ();

  pcx_rle_palette_decoder #(
    .MAX_DIM(MAX_DIM)
  ) dut (
    .clk   (clk),
    .rst   (rst),
    .stream(stream_if),
    .pixels(pixels_if),
    .cfg   (cfg_if)
  );

  // 2 ns clock
  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  // idling odds in percent, changed between parts of the run
  int src_idle_pct = 19;
  int snk_idle_pct = 80;

  // bookkeeping
  int unsigned words_sent     = 0;
  int unsigned pixels_checked = 0;
  int unsigned cfg_writes     = 0;
  int unsigned err_cnt        = 0;

  // decoder mirror: palette, run state, position and registers
  logic [23:0] pal_mem [pcxrle_pkg::PALETTE_SIZE];
  bit          pal_written [pcxrle_pkg::PALETTE_SIZE];
  bit          awaiting = 1'b0;
  logic [5:0]  run_len  = '0;
  int unsigned col_cnt  = 0;
  int unsigned row_cnt  = 0;
  bit          img_done = 1'b0;
  logic [12:0] reg_w    = 13'd1;
  logic [12:0] reg_h    = 13'd1;
  logic [12:0] reg_lb   = 13'd1;

  // pixels predicted but not yet seen, oldest first
  pcxrle_pkg::out_word_t pending_pixels [$];

  function automatic int unsigned clamp_dim(input logic [12:0] v);
    if (v > MAX_DIM) return MAX_DIM;
    return 32'(v);
  endfunction

  // advance the mirror by one accepted word and queue the pixels it yields
  function automatic void decode_word(input pcxrle_pkg::in_word_t w);
    int unsigned eff_w, eff_h, run, vis;
    logic [23:0] rgb;
    pcxrle_pkg::out_word_t px;
    eff_w = clamp_dim(reg_w);
    eff_h = clamp_dim(reg_h);
    if (w.op == pcxrle_pkg::OP_PALETTE) begin
      pal_mem[w.palette_index]     = {w.pal_red, w.pal_green, w.pal_blue};
      pal_written[w.palette_index] = 1'b1;
      return;
    end
    // past the last row, or height pulled below the current row
    if (img_done || row_cnt >= eff_h) return;
    // count byte opens a run, the next image byte is its value
    if (!awaiting && w.data_byte >= pcxrle_pkg::RUN_MARK) begin
      run_len  = w.data_byte[5:0];
      awaiting = 1'b1;
      return;
    end
    run      = awaiting ? 32'(run_len) : 1;
    awaiting = 1'b0;
    run_len  = '0;
    rgb      = pal_mem[w.data_byte];
    // only columns below the width come out
    vis = 0;
    if (col_cnt < eff_w) vis = (eff_w - col_cnt < run) ? eff_w - col_cnt : run;
    for (int unsigned k = 0; k < vis; k++) begin
      px.red          = rgb[23:16];
      px.green        = rgb[15:8];
      px.blue         = rgb[7:0];
      px.column       = 12'(col_cnt + k);
      px.row_index    = 12'(row_cnt);
      px.last_of_run  = (k + 1 == vis);
      px.end_of_image = (col_cnt + k + 1 == eff_w) && (row_cnt + 1 == eff_h);
      pending_pixels.push_back(px);
    end
    // column counter saturates, the row closes once it reaches line bytes
    col_cnt = (col_cnt + run > 32'(pcxrle_pkg::COL_SAT)) ? 32'(pcxrle_pkg::COL_SAT)
                                                          : col_cnt + run;
    if (col_cnt >= reg_lb) begin
      col_cnt = 0;
      if (row_cnt + 1 >= eff_h) img_done = 1'b1;
      else row_cnt = (row_cnt + 1) & 12'hFFF;
    end
  endfunction

  task automatic report_mismatch(input string msg);
    $display("tb_top: pixel %0d: %s", pixels_checked, msg);
    err_cnt++;
  endtask

  task automatic check_field(input string name, input logic [31:0] got,
                             input logic [31:0] want);
    if (got !== want) report_mismatch($sformatf("%s is %0h, predicted %0h", name, got, want));
  endtask

  // one word on the stream channel; valid stays up between back-to-back words
  task automatic send_word(input pcxrle_pkg::in_word_t w);
    while ($urandom_range(99) < src_idle_pct) begin
      stream_if.valid <= 1'b0;
      @(posedge clk);
    end
    stream_if.valid <= 1'b1;
    stream_if.data  <= w;
    @(posedge clk);
    while (!stream_if.ready) @(posedge clk);
    decode_word(w);
    words_sent++;
  endtask

  task automatic send_palette(input logic [7:0] idx, input logic [7:0] r,
                              input logic [7:0] g, input logic [7:0] b);
    pcxrle_pkg::in_word_t w;
    w = '{op: pcxrle_pkg::OP_PALETTE, data_byte: 8'($urandom), palette_index: idx,
          pal_red: r, pal_green: g, pal_blue: b};
    send_word(w);
  endtask

  // image byte; a value byte's entry is loaded first if unwritten, so no pixel shows an unwritten entry
  task automatic send_image(input logic [7:0] b);
    pcxrle_pkg::in_word_t w;
    if ((awaiting || b < pcxrle_pkg::RUN_MARK) && !pal_written[b])
      send_palette(b, 8'($urandom), 8'($urandom), 8'($urandom));
    w = '{op: pcxrle_pkg::OP_IMAGE, data_byte: b, palette_index: 8'($urandom),
          pal_red: 8'($urandom), pal_green: 8'($urandom), pal_blue: 8'($urandom)};
    send_word(w);
  endtask

  task automatic send_run(input logic [5:0] n, input logic [7:0] value);
    send_image(pcxrle_pkg::RUN_MARK | n);
    send_image(value);
  endtask

  // stop sending, wait for every predicted pixel, then let a silent byte finish
  task automatic drain_pixels();
    stream_if.valid <= 1'b0;
    @(posedge clk);
    while (pending_pixels.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // width, height, line bytes, then the unused index; only while idle
  task automatic set_dims(input logic [12:0] w, input logic [12:0] h, input logic [12:0] lb);
    pcxrle_pkg::cfg_word_t regs [4];
    regs[0] = '{index: pcxrle_pkg::REG_WIDTH, value: w};
    regs[1] = '{index: pcxrle_pkg::REG_HEIGHT, value: h};
    regs[2] = '{index: pcxrle_pkg::REG_LINE, value: lb};
    regs[3] = '{index: REG_SPARE, value: 13'($urandom)};
    foreach (regs[i]) begin
      cfg_if.valid <= 1'b1;
      cfg_if.data  <= regs[i];
      @(posedge clk);
      while (!cfg_if.ready) @(posedge clk);
      case (regs[i].index)
        pcxrle_pkg::REG_WIDTH:  reg_w  = regs[i].value;
        pcxrle_pkg::REG_HEIGHT: reg_h  = regs[i].value;
        pcxrle_pkg::REG_LINE:   reg_lb = regs[i].value;
        default: ;
      endcase
      cfg_writes++;
    end
    cfg_if.valid <= 1'b0;
  endtask

  // mostly small widths, now and then a full-width row
  task automatic pick_dims();
    logic [12:0] w, lb, h;
    case ($urandom_range(9))
      0:       w = 13'd4096;
      1, 2:    w = 13'($urandom_range(13, 80));
      default: w = 13'($urandom_range(1, 12));
    endcase
    if ($urandom_range(3) == 0) lb = 13'($urandom_range(0, w));
    else lb = w + 13'($urandom_range(0, 3));
    h = $urandom_range(1) ? 13'd4096 : 13'd8191;
    set_dims(w, h, lb);
  endtask

  // literals, padding, zero run, longest run, value bytes above the mark,
  // palette write inside a pending run
  task automatic test_directed_runs();
    drain_pixels();
    set_dims(13'd4, 13'd8191, 13'd6);
    send_palette(8'h00, 8'h00, 8'h00, 8'h00);
    send_palette(8'hFF, 8'hFF, 8'hFF, 8'hFF);
    send_palette(8'hBF, 8'h5A, 8'hA5, 8'h3C);
    send_palette(8'h80, 8'h0F, 8'hF0, 8'h81);
    // four visible columns, two padding columns close the row
    send_image(8'h00);
    send_image(8'hBF);
    send_image(8'h80);
    send_image(8'h00);
    send_image(8'h80);
    send_image(8'hBF);
    // count of zero eats its value byte
    send_run(6'd0, 8'h00);
    // 63 pixels spill far past the line
    send_run(6'd63, 8'hFF);
    // entry rewritten while the count waits for its value
    send_image(pcxrle_pkg::RUN_MARK | 8'd2);
    send_palette(8'hC0, 8'hC3, 8'h3C, 8'h99);
    send_image(8'hC0);
    send_run(6'd1, 8'hFF);
    send_image(8'h7F);
  endtask

  // width zero, line bytes zero, height under the row, height zero,
  // end of image flagged while the row is still open
  task automatic test_dim_corners();
    drain_pixels();
    set_dims(13'd0, 13'd4096, 13'd3);
    send_image(8'h41);
    send_run(6'd5, 8'h10);
    drain_pixels();
    set_dims(13'd4, 13'd4096, 13'd0);
    send_image(8'h20);
    send_run(6'd0, 8'h30);
    send_run(6'd5, 8'h40);
    send_image(8'h21);
    drain_pixels();
    set_dims(13'd4, 13'd1, 13'd5);
    send_image(8'h22);
    send_image(8'h23);
    send_image(pcxrle_pkg::RUN_MARK | 8'd4);
    drain_pixels();
    set_dims(13'd4, 13'd0, 13'd5);
    send_image(8'h24);
    send_image(8'h25);
    drain_pixels();
    set_dims(13'd3, 13'(row_cnt + 1), 13'd6);
    send_run(6'd3, 8'h55);
  endtask

  // widest settings: width limited to the maximum, line bytes just past it
  task automatic test_wide_row();
    int unsigned start_row, guard;
    drain_pixels();
    set_dims(13'd8191, 13'd8191, 13'd4160);
    start_row = row_cnt;
    guard     = 0;
    while (row_cnt == start_row && guard < 80) begin
      send_run(6'd63, guard[0] ? 8'hBF : 8'h80);
      guard++;
    end
  endtask

  // mostly well-formed literals and runs, some palette writes and stray bytes
  task automatic test_random_stream(input int unsigned n_words);
    int unsigned start, pick;
    start = words_sent;
    while (words_sent - start < n_words) begin
      pick = $urandom_range(99);
      if (pick < 10)
        send_palette(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
      else if (pick < 50)
        send_image(8'($urandom_range(0, pcxrle_pkg::RUN_MARK - 1)));
      else if (pick < 88)
        send_run(($urandom_range(3) != 0) ? 6'($urandom_range(0, 8)) :
                 6'($urandom_range(9, 63)), 8'($urandom));
      else
        send_image(8'($urandom));  // stray byte, may leave a run open
    end
  endtask

  task automatic test_random_phase();
    drain_pixels();
    pick_dims();
    test_random_stream(6);
    drain_pixels();
    pick_dims();
    test_random_stream(6);
  endtask

  // finish the image for real, then bytes must be ignored
  task automatic test_image_end();
    int unsigned guard;
    drain_pixels();
    set_dims(13'd3, 13'(row_cnt + 2), 13'd4);
    guard = 0;
    while (!img_done && guard < 100) begin
      if ($urandom_range(1)) send_image(8'($urandom_range(0, pcxrle_pkg::RUN_MARK - 1)));
      else send_run(6'($urandom_range(1, 5)), 8'($urandom));
      guard++;
    end
    send_palette(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
    repeat (6) send_image(8'($urandom));
    send_run(6'd63, 8'h00);
  endtask

  // receiver: ready decided fresh every cycle
  initial begin
    pixels_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      pixels_if.ready <= !rst && ($urandom_range(99) >= snk_idle_pct);
    end
  end

  // every pixel taken is matched against the oldest prediction
  always @(posedge clk) begin : check_pixels
    pcxrle_pkg::out_word_t want;
    if (!rst && pixels_if.valid === 1'b1 && pixels_if.ready === 1'b1) begin
      if (pending_pixels.size() == 0) begin
        report_mismatch("pixel arrived with none predicted");
      end else begin
        want = pending_pixels.pop_front();
        check_field("red", pixels_if.data.red, want.red);
        check_field("green", pixels_if.data.green, want.green);
        check_field("blue", pixels_if.data.blue, want.blue);
        check_field("column", pixels_if.data.column, want.column);
        check_field("row", pixels_if.data.row_index, want.row_index);
        check_field("last_of_run", pixels_if.data.last_of_run, want.last_of_run);
        check_field("end_of_image", pixels_if.data.end_of_image, want.end_of_image);
      end
      pixels_checked++;
    end
  end

  // sequence of tests
  initial begin
    rst             <= 1'b1;
    stream_if.valid <= 1'b0;
    stream_if.data  <= '0;
    cfg_if.valid    <= 1'b0;
    cfg_if.data     <= '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // sender idles lightly, receiver stalls hard
    src_idle_pct = 19;
    snk_idle_pct = 80;
    test_directed_runs();
    test_dim_corners();
    test_random_phase();

    // sender idles hard, receiver lightly
    src_idle_pct = 80;
    snk_idle_pct = 19;
    test_wide_row();
    test_random_phase();

    // full speed both ways
    src_idle_pct = 0;
    snk_idle_pct = 0;
    test_random_phase();
    test_image_end();

    drain_pixels();
    if (pending_pixels.size() != 0) report_mismatch("predicted pixels never arrived");
    $display("tb_top: %0d words sent, %0d register writes, %0d pixels compared",
             words_sent, cfg_writes, pixels_checked);
    $display("tb_top: covered runs to 63, zero runs, row padding and spill, limited and zero sizes");
    if (err_cnt == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end

  // hang guard
  initial begin
    #2_000_000;
    $display("tb_top: timeout with %0d pixels outstanding", pending_pixels.size());
    $display("tb_top: done, errors");
    $finish;
  end

endmodule
